// File: hw/rtl/sfas_pkg.sv
// shared types and constants for the status face animation sequencer
// no dependencies; imported by every module of the block
package sfas_pkg;

  // request actions
  typedef enum logic [2:0] {
    ACT_POLL     = 3'd0,
    ACT_INIT     = 3'd1,
    ACT_STANDBY  = 3'd2,
    ACT_DOWNLOAD = 3'd3,
    ACT_COMPLETE = 3'd4,
    ACT_ERROR    = 3'd5,
    ACT_RUNNING  = 3'd6,
    ACT_USER     = 3'd7
  } action_t;

  // display modes
  typedef enum logic [2:0] {
    MODE_BOOT     = 3'd0,
    MODE_STANDBY  = 3'd1,
    MODE_DOWNLOAD = 3'd2,
    MODE_COMPLETE = 3'd3,
    MODE_ERROR    = 3'd4,
    MODE_RUNNING  = 3'd5,
    MODE_USER     = 3'd6
  } mode_t;

  // icons shown on the face
  typedef enum logic [3:0] {
    ICON_STANDBY    = 4'd0,
    ICON_LOOK_LEFT  = 4'd1,
    ICON_LOOK_RIGHT = 4'd2,
    ICON_BLINK      = 4'd3,
    ICON_DOWNLOAD   = 4'd4,
    ICON_COMPLETE   = 4'd5,
    ICON_ERROR      = 4'd6,
    ICON_RUNNING    = 4'd7,
    ICON_CLEAR      = 4'd8,
    ICON_USER       = 4'd9
  } icon_t;

  // configuration register indexes
  localparam logic [2:0] REG_FEEDBACK = 3'd0;
  localparam logic [2:0] REG_IDLE_MIN = 3'd1;
  localparam logic [2:0] REG_LOOK     = 3'd2;
  localparam logic [2:0] REG_HOLD     = 3'd3;
  localparam logic [2:0] REG_BLINK    = 3'd4;

  // register reset values
  localparam logic [15:0] FEEDBACK_RST = 16'd800;
  localparam logic [15:0] IDLE_MIN_RST = 16'd4500;
  localparam logic [11:0] LOOK_RST     = 12'd320;
  localparam logic [11:0] HOLD_RST     = 12'd120;
  localparam logic [11:0] BLINK_RST    = 12'd90;

  // lfsr seed and feedback taps
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // phase values in the idle cycle
  localparam logic [2:0] PHASE_LOOK    = 3'd1;
  localparam logic [2:0] PHASE_HOLD    = 3'd2;
  localparam logic [2:0] PHASE_RESTART = 3'd4;

  // classified request passed from front to back
  typedef struct packed {
    action_t     op;
    logic [31:0] now;
    logic [31:0] now_idle;   // now plus minimum idle wait
    logic [31:0] now_fb;     // now plus feedback time
  } cmd_t;

  // frame durations used by the back part
  typedef struct packed {
    logic [11:0] look_ms;
    logic [11:0] hold_ms;
    logic [11:0] blink_ms;
  } dur_t;

endpackage

// File: hw/rtl/status_face_animation_sequencer_top.sv
// status face animation sequencer: an accepted request is registered in the
// queue, then its result in the result register; throughput one request per
// cycle while m_tready is high. the back part pops the queue head into the
// result register; QUEUE_DEPTH entries let the front accept under stall until full.
// synchronous reset restores config defaults, boot mode, lfsr seed 0xACE1
// and an empty queue; no clearing pass is needed.
// depends on sfas_pkg, sfas_front, sfas_queue, sfas_exec
module status_face_animation_sequencer_top
  import sfas_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // action[2:0], now_ms[34:3], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // icon_valid[0], icon[4:1], accepted[5], mode[8:6]
);

  cmd_t cmd;
  cmd_t head;
  dur_t dur;
  logic full;
  logic empty;
  logic pop;
  logic push;

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  // front: config registers and request classification
  sfas_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .action    (s_tdata[2:0]),
    .now_ms    (s_tdata[34:3]),
    .cmd       (cmd),
    .dur       (dur)
  );

  // request queue
  sfas_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  // back: state update and result register
  sfas_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (head),
    .dur      (dur),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: hw/rtl/sfas_front.sv
// front part: configuration registers and request classification
// depends on sfas_pkg
module sfas_front
  import sfas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [2:0]  action,
  input  logic [31:0] now_ms,
  output cmd_t        cmd,
  output dur_t        dur
);

  logic [15:0] feedback_ms;
  logic [15:0] idle_wait;
  logic [11:0] look_ms;
  logic [11:0] hold_ms;
  logic [11:0] blink_ms;

  // configuration register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_ms <= FEEDBACK_RST;
      idle_wait   <= IDLE_MIN_RST;
      look_ms     <= LOOK_RST;
      hold_ms     <= HOLD_RST;
      blink_ms    <= BLINK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FEEDBACK: feedback_ms <= cfg_data;
        REG_IDLE_MIN: idle_wait   <= cfg_data;
        REG_LOOK:     look_ms     <= cfg_data[11:0];
        REG_HOLD:     hold_ms     <= cfg_data[11:0];
        REG_BLINK:    blink_ms    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // classify the request and precompute the config-based deadlines
  always_comb begin
    cmd.op       = action_t'(action);
    cmd.now      = now_ms;
    cmd.now_idle = now_ms + {16'd0, idle_wait};
    cmd.now_fb   = now_ms + {16'd0, feedback_ms};
  end

  assign dur.look_ms  = look_ms;
  assign dur.hold_ms  = hold_ms;
  assign dur.blink_ms = blink_ms;

endmodule

// File: hw/rtl/sfas_queue.sv
// short request queue between front and back parts
// depends on sfas_pkg
module sfas_queue
  import sfas_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = entry[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/sfas_exec.sv
// back part: mode, deadline, lfsr and idle animation state, result register
// depends on sfas_pkg
module sfas_exec
  import sfas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  cmd_t        head,
  input  dur_t        dur,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata
);

  mode_t       ui_mode;
  logic [31:0] wake_time;
  logic [15:0] random_reg;
  logic [2:0]  anim_phase;
  logic        look_right;

  mode_t       ui_mode_next;
  logic [31:0] wake_time_next;
  logic [15:0] random_reg_next;
  logic [2:0]  anim_phase_next;
  logic        look_right_next;

  logic        res_valid;
  icon_t       res_icon;
  logic        res_acc;

  logic [15:0] lfsr_step;
  logic [31:0] standby_wake;
  logic [31:0] diff;
  logic        reached;
  logic [2:0]  phase_inc;
  logic [11:0] dur_sel;
  logic [31:0] frame_wake;

  // pop when the result register is free or being drained
  assign pop = !empty && (!m_tvalid || m_tready);

  // shared datapath pieces
  always_comb begin
    lfsr_step    = {1'b0, random_reg[15:1]} ^ (random_reg[0] ? LFSR_TAPS : 16'd0);
    standby_wake = head.now_idle + {20'd0, lfsr_step[11:0]};
    diff         = head.now - wake_time;
    reached      = !diff[31];
    phase_inc    = anim_phase + 3'd1;
    case (phase_inc)
      PHASE_LOOK: dur_sel = dur.look_ms;
      PHASE_HOLD: dur_sel = dur.hold_ms;
      default:    dur_sel = dur.blink_ms;
    endcase
    frame_wake = head.now + {20'd0, dur_sel};
  end

  // next state and result for the request at the queue head
  always_comb begin
    ui_mode_next    = ui_mode;
    wake_time_next  = wake_time;
    random_reg_next = random_reg;
    anim_phase_next = anim_phase;
    look_right_next = look_right;
    res_valid       = 1'b0;
    res_icon        = ICON_STANDBY;
    res_acc         = 1'b0;

    unique case (head.op)
      ACT_POLL: begin
        if (reached) begin
          if (ui_mode == MODE_COMPLETE || ui_mode == MODE_ERROR ||
              (ui_mode == MODE_STANDBY && phase_inc == PHASE_RESTART)) begin
            // (re)enter standby with a fresh random idle delay
            ui_mode_next    = MODE_STANDBY;
            random_reg_next = lfsr_step;
            wake_time_next  = standby_wake;
            anim_phase_next = 3'd0;
            look_right_next = lfsr_step[0];
            res_valid       = 1'b1;
          end else if (ui_mode == MODE_STANDBY) begin
            anim_phase_next = phase_inc;
            wake_time_next  = frame_wake;
            res_valid       = 1'b1;
            case (phase_inc)
              PHASE_LOOK: res_icon = look_right ? ICON_LOOK_RIGHT : ICON_LOOK_LEFT;
              PHASE_HOLD: res_icon = ICON_STANDBY;
              default:    res_icon = ICON_BLINK;
            endcase
          end
        end
      end
      ACT_INIT: begin
        ui_mode_next    = MODE_BOOT;
        wake_time_next  = 32'd0;
        anim_phase_next = 3'd0;
        look_right_next = 1'b0;
        res_valid       = 1'b1;
        res_icon        = ICON_CLEAR;
      end
      ACT_STANDBY: begin
        ui_mode_next    = MODE_STANDBY;
        random_reg_next = lfsr_step;
        wake_time_next  = standby_wake;
        anim_phase_next = 3'd0;
        look_right_next = lfsr_step[0];
        res_valid       = 1'b1;
      end
      ACT_DOWNLOAD: begin
        ui_mode_next   = MODE_DOWNLOAD;
        wake_time_next = 32'd0;
        res_valid      = 1'b1;
        res_icon       = ICON_DOWNLOAD;
      end
      ACT_COMPLETE: begin
        ui_mode_next   = MODE_COMPLETE;
        wake_time_next = head.now_fb;
        res_valid      = 1'b1;
        res_icon       = ICON_COMPLETE;
      end
      ACT_ERROR: begin
        ui_mode_next   = MODE_ERROR;
        wake_time_next = head.now_fb;
        res_valid      = 1'b1;
        res_icon       = ICON_ERROR;
      end
      ACT_RUNNING: begin
        ui_mode_next   = MODE_RUNNING;
        wake_time_next = 32'd0;
        res_valid      = 1'b1;
        res_icon       = ICON_RUNNING;
      end
      ACT_USER: begin
        if (ui_mode == MODE_RUNNING || ui_mode == MODE_USER) begin
          ui_mode_next = MODE_USER;
          res_valid    = 1'b1;
          res_icon     = ICON_USER;
          res_acc      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ui_mode    <= MODE_BOOT;
      wake_time  <= 32'd0;
      random_reg <= LFSR_SEED;
      anim_phase <= 3'd0;
      look_right <= 1'b0;
    end else if (pop) begin
      ui_mode    <= ui_mode_next;
      wake_time  <= wake_time_next;
      random_reg <= random_reg_next;
      anim_phase <= anim_phase_next;
      look_right <= look_right_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {7'd0, ui_mode_next, res_acc, res_icon, res_valid};
    end
  end

endmodule

// File: dv/status_face_animation_sequencer_top_tb.sv
// testbench for the status face animation sequencer top level
// self-checking: a scoreboard class predicts each result from the accepted requests
// depends on sfas_pkg and status_face_animation_sequencer_top
`timescale 1ns / 100ps

module status_face_animation_sequencer_top_tb;
  import sfas_pkg::*;

  // result layout, lowest bit first: icon_valid, icon, accepted, mode
  typedef struct packed {
    mode_t mode;
    logic  accepted;
    icon_t icon;
    logic  icon_valid;
  } face_result_t;

  // mirror of the sequencer state and the queue of expected results
  class face_tracker;
    mode_t        mode;
    logic [31:0]  wake;
    logic [15:0]  lfsr;
    logic [2:0]   phase;
    logic         gaze_right;
    logic [15:0]  feedback;
    logic [15:0]  idle_min;
    logic [11:0]  look;
    logic [11:0]  hold;
    logic [11:0]  blink;
    face_result_t expected_faces[$];
    int           mismatches;

    function new();
      mode       = MODE_BOOT;
      wake       = '0;
      lfsr       = LFSR_SEED;
      phase      = '0;
      gaze_right = 1'b0;
      feedback   = FEEDBACK_RST;
      idle_min   = IDLE_MIN_RST;
      look       = LOOK_RST;
      hold       = HOLD_RST;
      blink      = BLINK_RST;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_FEEDBACK: feedback = val;
        REG_IDLE_MIN: idle_min = val;
        REG_LOOK:     look     = val[11:0];
        REG_HOLD:     hold     = val[11:0];
        REG_BLINK:    blink    = val[11:0];
        default: ;
      endcase
    endfunction

    // deadline passed when the wrapped difference is not negative
    function logic deadline_met(logic [31:0] now);
      logic [31:0] diff;
      diff = now - wake;
      return !diff[31];
    endfunction

    // one lfsr step, new idle deadline and gaze side
    function void restart_idle(logic [31:0] now);
      lfsr       = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);
      mode       = MODE_STANDBY;
      wake       = now + {16'd0, idle_min} + {20'd0, lfsr[11:0]};
      phase      = '0;
      gaze_right = lfsr[0];
    endfunction

    function face_result_t advance(action_t act, logic [31:0] now);
      face_result_t res;
      res.icon_valid = 1'b0;
      res.icon       = ICON_STANDBY;
      res.accepted   = 1'b0;
      case (act)
        ACT_POLL: begin
          if (deadline_met(now)) begin
            if (mode == MODE_COMPLETE || mode == MODE_ERROR) begin
              restart_idle(now);
              res.icon_valid = 1'b1;
            end else if (mode == MODE_STANDBY) begin
              phase = phase + 3'd1;
              res.icon_valid = 1'b1;
              if (phase == 3'd4) begin
                restart_idle(now);
              end else if (phase == 3'd1) begin
                res.icon = gaze_right ? ICON_LOOK_RIGHT : ICON_LOOK_LEFT;
                wake     = now + {20'd0, look};
              end else if (phase == 3'd2) begin
                wake = now + {20'd0, hold};
              end else begin
                res.icon = ICON_BLINK;
                wake     = now + {20'd0, blink};
              end
            end
          end
        end
        ACT_INIT: begin
          mode       = MODE_BOOT;
          wake       = '0;
          phase      = '0;
          gaze_right = 1'b0;
          res.icon_valid = 1'b1;
          res.icon       = ICON_CLEAR;
        end
        ACT_STANDBY: begin
          restart_idle(now);
          res.icon_valid = 1'b1;
        end
        ACT_DOWNLOAD: begin
          mode = MODE_DOWNLOAD;
          wake = '0;
          res.icon_valid = 1'b1;
          res.icon       = ICON_DOWNLOAD;
        end
        ACT_COMPLETE: begin
          mode = MODE_COMPLETE;
          wake = now + {16'd0, feedback};
          res.icon_valid = 1'b1;
          res.icon       = ICON_COMPLETE;
        end
        ACT_ERROR: begin
          mode = MODE_ERROR;
          wake = now + {16'd0, feedback};
          res.icon_valid = 1'b1;
          res.icon       = ICON_ERROR;
        end
        ACT_RUNNING: begin
          mode = MODE_RUNNING;
          wake = '0;
          res.icon_valid = 1'b1;
          res.icon       = ICON_RUNNING;
        end
        default: begin
          // user pattern only taken while running or already showing one
          if (mode == MODE_RUNNING || mode == MODE_USER) begin
            mode = MODE_USER;
            res.icon_valid = 1'b1;
            res.icon       = ICON_USER;
            res.accepted   = 1'b1;
          end
        end
      endcase
      res.mode = mode;
      return res;
    endfunction

    function void note_request(action_t act, logic [31:0] now);
      expected_faces.push_back(advance(act, now));
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [15:0] data);
      face_result_t got;
      face_result_t want;
      got = face_result_t'(data[8:0]);
      if (expected_faces.size() == 0) begin
        report($sformatf("unexpected result %h", data));
        return;
      end
      want = expected_faces.pop_front();
      if (got.icon_valid !== want.icon_valid)
        report($sformatf("icon_valid %b, wanted %b", got.icon_valid, want.icon_valid));
      if (got.icon !== want.icon)
        report($sformatf("icon %0d, wanted %0d", got.icon, want.icon));
      if (got.accepted !== want.accepted)
        report($sformatf("accepted %b, wanted %b", got.accepted, want.accepted));
      if (got.mode !== want.mode)
        report($sformatf("mode %0d, wanted %0d", got.mode, want.mode));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // action[2:0], now_ms[34:3], zero pad
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // icon_valid[0], icon[4:1], accepted[5], mode[8:6]

  face_tracker tracker;
  logic        gaps_on;
  logic        hold_request;

  status_face_animation_sequencer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // offer one request and wait until the block takes it
  task automatic send_item(input action_t act, input logic [31:0] now);
    while (gaps_on && $urandom_range(99) < 27) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {5'd0, now, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_request(act, now);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // hold off new requests until every expected result is back
  task automatic drain();
    while (tracker.expected_faces.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  // poll times mostly around the current deadline, some at the signed edge
  function automatic logic [31:0] poll_time();
    int r;
    r = $urandom_range(99);
    if (r < 50) return tracker.wake + $urandom_range(6);
    if (r < 65) return tracker.wake - 32'd1 - $urandom_range(5);
    if (r < 75) return tracker.wake + 32'h7FFF_FFFF + $urandom_range(1);
    return $urandom();
  endfunction

  // scenarios with random content, plus a share of pure noise
  task automatic run_random(input int count);
    int sent;
    int kind;
    int n;
    action_t act;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      n    = 2 + $urandom_range(8);
      if (kind < 30) begin
        send_item(ACT_STANDBY, $urandom());
        repeat (n) send_item(ACT_POLL, poll_time());
      end else if (kind < 55) begin
        send_item($urandom_range(1) ? ACT_COMPLETE : ACT_ERROR, $urandom());
        repeat (n) send_item(ACT_POLL, poll_time());
      end else if (kind < 70) begin
        send_item(ACT_RUNNING, $urandom());
        repeat (n) send_item($urandom_range(3) ? ACT_USER : ACT_POLL, poll_time());
      end else if (kind < 80) begin
        send_item($urandom_range(1) ? ACT_DOWNLOAD : ACT_INIT, $urandom());
        repeat (n) send_item($urandom_range(1) ? ACT_USER : ACT_POLL, poll_time());
      end else begin
        repeat (n) begin
          act = action_t'($urandom_range(7));
          send_item(act, (act == ACT_POLL) ? poll_time() : $urandom());
        end
      end
      sent += n + 1;
    end
  endtask

  // result side: random back-pressure and one long hold-off on request
  initial begin
    int   hold_left;
    logic hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    m_tready   = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_left  = 80;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = !gaps_on || ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    tracker      = new();
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    gaps_on      = 1'b1;
    hold_request = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed walk through every mode with reset settings
    send_item(ACT_POLL, 32'd0);
    send_item(ACT_USER, 32'd0);
    send_item(ACT_INIT, 32'hFFFF_FFFF);
    send_item(ACT_STANDBY, 32'hFFFF_FF00);
    send_item(ACT_POLL, tracker.wake - 32'd1);
    send_item(ACT_POLL, tracker.wake + 32'h8000_0000);
    send_item(ACT_POLL, tracker.wake);
    send_item(ACT_POLL, tracker.wake);
    send_item(ACT_POLL, tracker.wake);
    send_item(ACT_POLL, tracker.wake + 32'h7FFF_FFFF);
    send_item(ACT_DOWNLOAD, $urandom());
    send_item(ACT_POLL, tracker.wake);
    send_item(ACT_COMPLETE, 32'd0);
    send_item(ACT_POLL, tracker.wake - 32'd1);
    send_item(ACT_POLL, tracker.wake);
    send_item(ACT_ERROR, 32'hFFFF_FFF0);
    send_item(ACT_POLL, tracker.wake);
    send_item(ACT_RUNNING, $urandom());
    send_item(ACT_POLL, 32'd0);
    send_item(ACT_USER, $urandom());
    send_item(ACT_USER, $urandom());
    send_item(ACT_INIT, 32'd0);
    send_item(ACT_USER, 32'd0);
    run_random(300);

    // all registers at zero, no idling on either side
    drain();
    write_reg(REG_FEEDBACK, 16'h0000);
    write_reg(REG_IDLE_MIN, 16'h0000);
    write_reg(REG_LOOK, 16'h0000);
    write_reg(REG_HOLD, 16'h0000);
    write_reg(REG_BLINK, 16'h0000);
    gaps_on = 1'b0;
    run_random(300);
    gaps_on = 1'b1;

    // all registers at their top, with a long result stall
    drain();
    write_reg(REG_FEEDBACK, 16'hFFFF);
    write_reg(REG_IDLE_MIN, 16'hFFFF);
    write_reg(REG_LOOK, 16'hFFFF);
    write_reg(REG_HOLD, 16'hFFFF);
    write_reg(REG_BLINK, 16'hFFFF);
    hold_request = 1'b1;
    run_random(350);

    // random settings; writes to unused indexes must be ignored
    drain();
    write_reg(REG_FEEDBACK, 16'($urandom()));
    write_reg(REG_IDLE_MIN, 16'($urandom()));
    write_reg(REG_LOOK, 16'($urandom()));
    write_reg(REG_HOLD, 16'($urandom()));
    write_reg(REG_BLINK, 16'($urandom()));
    write_reg(3'd5, 16'($urandom()));
    write_reg(3'd6, 16'hFFFF);
    write_reg(3'd7, 16'($urandom()));
    run_random(180);
    drain();
    run_random(180);

    // wait for the last results, bounded
    for (int i = 0; i < 5000 && tracker.expected_faces.size() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.expected_faces.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.expected_faces.size()));
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/sfas_pkg.sv
hw/rtl/sfas_front.sv
hw/rtl/sfas_queue.sv
hw/rtl/sfas_exec.sv
hw/rtl/status_face_animation_sequencer_top.sv
dv/status_face_animation_sequencer_top_tb.sv
